// ----- rtl/sdf_pkg.sv -----
// Shared types, constants and helpers for the stereo decimating FIR filter.
// No dependencies; used by sdf_mac and the top level.
`default_nettype none

package sdf_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_TAPS_DEF     = 512;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEFF_WIDTH_DEF  = 16;
  localparam int ACC_WIDTH_DEF    = 48;

  // Fixed field and register widths
  localparam int COEFF_INDEX_W = 9;
  localparam int TAP_CFG_W     = 9;
  localparam int DECIM_W       = 3;
  localparam int FRAME_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd2;

  // Register reset values
  localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RST = 9'd511;
  localparam logic [DECIM_W-1:0]   DECIM_RST     = 3'd1;
  localparam logic [FRAME_W-1:0]   FRAME_LEN_RST = 16'd256;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEFF  = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic valid;  // coefficient and sample read data present this cycle
  } mac_ctl_t;

  // (v mod f) for v <= 8 and f >= 1
  function automatic logic [DECIM_W-1:0] mod_small(input logic [DECIM_W:0] v,
                                                   input logic [DECIM_W-1:0] f);
    logic [DECIM_W:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= {1'b0, f}) begin
        r = r - {1'b0, f};
      end
    end
    return r[DECIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/stereo_decimating_fir_filter.sv -----
// Top level of the stereo decimating FIR filter: sequencer, config registers,
// delay-line and coefficient RAMs. Depends on sdf_pkg, sdf_ram, sdf_mac.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   kind, sample, coeff_index, coeff_value
//  out      source     out_valid_o / out_stall_i filtered_value, last, channel
//  cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// A coefficient beat or a sample that yields no result is taken in ST_IDLE and
// leaves the sequencer idle. A sample that yields a result first reduces the start
// index, then walks the taps on the shared multiplier and RAM read ports, drains.
// After reset the delay lines are zeroed; no beat is taken until that is done.
// A waiting result is held under out_stall_i while the next beat is accepted;
// a new result waits in the sequencer until the output register frees up.
`default_nettype none

module stereo_decimating_fir_filter #(
  parameter int MAX_TAPS     = sdf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = sdf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = sdf_pkg::COEFF_WIDTH_DEF,
  parameter int ACC_WIDTH    = sdf_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [sdf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  kind_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  wire logic [sdf_pkg::COEFF_INDEX_W-1:0]     coeff_index_i,
  input  wire logic signed [COEFF_WIDTH-1:0]         coeff_value_i,
  // output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [ACC_WIDTH-1:0]                filtered_value_o,
  output logic                                       last_o,
  output logic                                       channel_o
);

  localparam int PW = $clog2(MAX_TAPS);      // address / pointer width
  localparam int TW = PW + 1;                // tap count width
  localparam int RW = 2 * PW + 1;            // reduction compare width
  localparam int SW = $clog2(PW + 1);        // reduction step counter width
  localparam int DW = sdf_pkg::DECIM_W;
  localparam int FW = sdf_pkg::FRAME_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // config registers
  logic [sdf_pkg::TAP_CFG_W-1:0] cfg_taps_q;
  logic [DW-1:0]                 cfg_decim_q;
  logic [FW-1:0]                 cfg_frame_q;

  // sequencer state
  state_e        state_q;
  logic [PW-1:0] clr_addr_q;
  logic [PW-1:0] lptr_q, rptr_q;
  logic [DW-1:0] ldec_q, rdec_q;
  logic [FW-1:0] frame_cnt_q;
  logic          left_turn_q;
  logic          chan_q;
  logic          last_q;
  logic [TW-1:0] taps_q;
  logic [PW-1:0] r_q;
  logic [PW-1:0] k_q;
  logic [SW-1:0] shift_q;
  logic          iss_q;

  // output register
  logic                        out_valid_q;
  logic signed [ACC_WIDTH-1:0] out_value_q;
  logic                        out_last_q;
  logic                        out_chan_q;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_taps_q  <= sdf_pkg::TAP_COUNT_RST;
      cfg_decim_q <= sdf_pkg::DECIM_RST;
      cfg_frame_q <= sdf_pkg::FRAME_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sdf_pkg::REG_TAP_COUNT: cfg_taps_q  <= cfg_data_i[sdf_pkg::TAP_CFG_W-1:0];
        sdf_pkg::REG_DECIM:     cfg_decim_q <= cfg_data_i[DW-1:0];
        sdf_pkg::REG_FRAME_LEN: cfg_frame_q <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Beat decode
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          smp_acc;
  logic          coef_acc;
  logic          coef_in_range;
  logic          cur_chan;
  logic [PW-1:0] cur_ptr;
  logic [DW-1:0] cur_dec;
  logic [PW-1:0] tap_lim;
  logic [TW-1:0] taps;
  logic [DW-1:0] factor;
  logic [PW-1:0] ptr_next;
  logic [DW-1:0] dec_next;
  logic          compute;
  logic [FW:0]   frame_inc;
  logic          frame_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp_acc    = in_acc && (kind_i == sdf_pkg::KIND_SAMPLE);
  assign coef_acc   = in_acc && (kind_i == sdf_pkg::KIND_COEFF);

  assign coef_in_range = 32'(coeff_index_i) < 32'(MAX_TAPS);

  assign cur_chan = left_turn_q;
  assign cur_ptr  = cur_chan ? lptr_q : rptr_q;
  assign cur_dec  = cur_chan ? ldec_q : rdec_q;

  always_comb begin
    if (32'(cfg_taps_q) >= 32'(MAX_TAPS)) begin
      tap_lim = PW'(MAX_TAPS - 1);
    end else begin
      tap_lim = PW'(cfg_taps_q);
    end
  end

  assign taps     = TW'(tap_lim) + TW'(1);
  assign factor   = (cfg_decim_q == '0) ? DW'(1) : cfg_decim_q;
  assign ptr_next = (cur_ptr == '0) ? tap_lim : cur_ptr - PW'(1);
  assign dec_next = sdf_pkg::mod_small({1'b0, cur_dec} + (DW+1)'(1), factor);
  assign compute  = (cur_dec == '0);

  // last when the count reaches frame_length - 1 or beyond
  assign frame_inc  = {1'b0, frame_cnt_q} + (FW+1)'(1);
  assign frame_last = (cfg_frame_q == '0) || (frame_inc >= {1'b0, cfg_frame_q});

  // ---------------------------------------------------------------------------
  // Start index reduction: r mod taps, one compare-subtract per step
  // ---------------------------------------------------------------------------
  logic [RW-1:0] div_shift;
  logic [RW-1:0] r_wide;
  logic          sub_ok;
  logic [PW-1:0] r_sub;

  assign div_shift = RW'(taps_q) << shift_q;
  assign r_wide    = RW'(r_q);
  assign sub_ok    = (r_wide >= div_shift);
  assign r_sub     = PW'(r_wide - div_shift);

  // ---------------------------------------------------------------------------
  // Tap walk
  // ---------------------------------------------------------------------------
  logic [PW-1:0] r_step;
  logic          k_last;

  assign r_step = (({1'b0, r_q} + TW'(1)) == taps_q) ? '0 : r_q + PW'(1);
  assign k_last = (k_q == PW'(taps_q - TW'(1)));

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                    clearing;
  logic                    lwe, rwe;
  logic [PW-1:0]           line_waddr;
  logic [SAMPLE_WIDTH-1:0] line_wdata;
  logic [SAMPLE_WIDTH-1:0] lrd, rrd;
  logic [COEFF_WIDTH-1:0]  crd;

  assign clearing   = (state_q == ST_CLEAR);
  assign lwe        = clearing || (smp_acc && cur_chan);
  assign rwe        = clearing || (smp_acc && !cur_chan);
  assign line_waddr = clearing ? clr_addr_q : cur_ptr;
  assign line_wdata = clearing ? '0 : sample_i;

  sdf_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_WIDTH)) u_left_line (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (r_q),
    .rdata_o (lrd)
  );

  sdf_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_WIDTH)) u_right_line (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (r_q),
    .rdata_o (rrd)
  );

  sdf_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEFF_WIDTH)) u_coeff (
    .clk_i   (clk_i),
    .we_i    (coef_acc && coef_in_range),
    .waddr_i (PW'(coeff_index_i)),
    .wdata_i (coeff_value_i),
    .raddr_i (k_q),
    .rdata_o (crd)
  );

  // ---------------------------------------------------------------------------
  // Multiply-accumulate
  // ---------------------------------------------------------------------------
  sdf_pkg::mac_ctl_t           mac_ctl;
  logic                        mac_busy;
  logic signed [ACC_WIDTH-1:0] mac_acc;

  assign mac_ctl.clear = (state_q == ST_REDUCE);
  assign mac_ctl.valid = iss_q;

  sdf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .coeff_i  (crd),
    .sample_i (chan_q ? lrd : rrd),
    .busy_o   (mac_busy),
    .acc_o    (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      lptr_q      <= '0;
      rptr_q      <= '0;
      ldec_q      <= '0;
      rdec_q      <= '0;
      frame_cnt_q <= '0;
      left_turn_q <= 1'b0;
      chan_q      <= 1'b0;
      last_q      <= 1'b0;
      taps_q      <= '0;
      r_q         <= '0;
      k_q         <= '0;
      shift_q     <= '0;
      iss_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
      out_chan_q  <= 1'b0;
    end else begin
      iss_q <= (state_q == ST_MAC);
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + PW'(1);
          if (clr_addr_q == PW'(MAX_TAPS - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (smp_acc) begin
            if (cur_chan) begin
              lptr_q <= ptr_next;
              ldec_q <= dec_next;
            end else begin
              rptr_q <= ptr_next;
              rdec_q <= dec_next;
            end
            left_turn_q <= !cur_chan;
            if (compute) begin
              chan_q      <= cur_chan;
              taps_q      <= taps;
              r_q         <= cur_ptr;
              shift_q     <= SW'(PW - 1);
              last_q      <= frame_last;
              frame_cnt_q <= frame_last ? '0 : frame_inc[FW-1:0];
              state_q     <= ST_REDUCE;
            end
          end
        end

        ST_REDUCE: begin
          if (sub_ok) begin
            r_q <= r_sub;
          end
          if (shift_q == '0) begin
            k_q     <= '0;
            state_q <= ST_MAC;
          end else begin
            shift_q <= shift_q - SW'(1);
          end
        end

        ST_MAC: begin
          // read issued at k_q / r_q this cycle
          k_q   <= k_q + PW'(1);
          r_q   <= r_step;
          if (k_last) begin
            state_q <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          if (!iss_q && !mac_busy) begin
            state_q <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            out_value_q <= mac_acc;
            out_last_q  <= last_q;
            out_chan_q  <= chan_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign last_o           = out_last_q;
  assign channel_o        = out_chan_q;

endmodule

`default_nettype wire

// ----- rtl/sdf_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sdf_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/sdf_mac.sv -----
// Shared multiply-accumulate unit: registered product, then wrapping accumulator.
// Depends on sdf_pkg (mac_ctl_t).
`default_nettype none

module sdf_mac #(
  parameter int SAMPLE_WIDTH = sdf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = sdf_pkg::COEFF_WIDTH_DEF,
  parameter int ACC_WIDTH    = sdf_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sdf_pkg::mac_ctl_t              ctl_i,
  input  wire logic signed [COEFF_WIDTH-1:0]  coeff_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                                busy_o,
  output logic signed [ACC_WIDTH-1:0]         acc_o
);

  localparam int PW = SAMPLE_WIDTH + COEFF_WIDTH;

  logic signed [PW-1:0]        prod_q;
  logic                        prod_vld_q;
  logic signed [ACC_WIDTH-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_q     <= '0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctl_i.valid;
      prod_q     <= coeff_i * sample_i;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        // size cast sign-extends or truncates; the sum wraps at ACC_WIDTH
        acc_q <= acc_q + ACC_WIDTH'(prod_q);
      end
    end
  end

  assign busy_o = prod_vld_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire
